// ----- rtl/clook_pkg.sv -----
// Shared types and constants for the C-LOOK disk request queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package clook_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_TRACK_BITS  = 16;
	localparam int DEF_TAG_BITS    = 16;

	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TAKE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_UPD
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic commit;
	} ctl_t;

endpackage

// ----- rtl/clook_disk_request_queue.sv -----
// C-LOOK disk request queue, top level.
// Input item: tuser is the action (add or take); tdata carries the tag, the
// request track and the head track. Output item: tuser is the status; tdata
// carries the taken tag and track and the now-empty flag.
// Every accepted item gives exactly one result item, in order.
// An add places the request by track order into the current sweep or the
// wrap segment; a take pops the front entry. A full queue drops an add with
// status FULL; a take on an empty queue reports status EMPTY.
// An item is accepted in the idle state, the compare of its track against
// every cell is registered, and the shift of the cell row commits in the
// update state once the output register is free, loading the output
// register. One item is in work at a time: no new item is accepted until
// the current one has committed.
// While a result waits in the output register the next item is still
// accepted; its commit waits until the receiver takes the pending result.
// Reset empties the queue (cell contents are not cleared), returns the
// controller to idle and clears the output valid flag.
// Depends on clook_pkg, clook_ctrl and clook_datapath.
module clook_disk_request_queue
	import clook_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int TRACK_BITS  = DEF_TRACK_BITS,
	parameter int TAG_BITS    = DEF_TAG_BITS,
	parameter int IN_DATA_W   = ((TAG_BITS + 2 * TRACK_BITS + 7) / 8) * 8,
	parameter int OUT_DATA_W  = ((TAG_BITS + TRACK_BITS + 1 + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// request_tag, request_track, head_track, zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_tag, out_track, now_empty, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [1:0]            m_tuser
);

	ctl_t                  ctl;
	status_t               status;
	logic [TAG_BITS-1:0]   out_tag;
	logic [TRACK_BITS-1:0] out_track;
	logic                  now_empty;

	clook_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.ctl       (ctl)
	);

	clook_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TRACK_BITS  (TRACK_BITS),
		.TAG_BITS    (TAG_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.action        (s_tuser),
		.request_tag   (s_tdata[TAG_BITS-1:0]),
		.request_track (s_tdata[TAG_BITS +: TRACK_BITS]),
		.head_track    (s_tdata[TAG_BITS + TRACK_BITS +: TRACK_BITS]),
		.status        (status),
		.out_tag       (out_tag),
		.out_track     (out_track),
		.now_empty     (now_empty)
	);

	assign m_tdata = OUT_DATA_W'({now_empty, out_track, out_tag});
	assign m_tuser = status;

	localparam int EMPTY_BIT = TAG_BITS + TRACK_BITS;

	// One item is in work at a time, so the input closes right after an accept.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is still in work");

	// A new result only appears after the update state of an item, in which the input is closed.
	a_result_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without an item in work");

	a_empty_take: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[EMPTY_BIT]
			&& m_tdata[EMPTY_BIT-1:0] == '0)
		else $error("empty take reported a request or a nonempty queue");

	a_full_add: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FULL |-> !m_tdata[EMPTY_BIT])
		else $error("full add reported an empty queue");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 2'd3)
		else $error("undefined status code");

endmodule

// ----- rtl/clook_ctrl.sv -----
// Controller of the C-LOOK request queue: takes an item, then commits it when
// the output register is free. Depends on clook_pkg.
module clook_ctrl
	import clook_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output ctl_t ctl
);

	state_t state_q, state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_next = S_UPD;
			end
			S_UPD: begin
				if (out_free) state_next = S_IDLE;
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		ctl.load_in = 1'b0;
		ctl.commit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				ctl.load_in = in_valid;
			end
			S_UPD: begin
				ctl.commit = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (ctl.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/clook_datapath.sv -----
// Datapath of the C-LOOK request queue: a row of sorted cells with a compare
// per cell, the count and wrap registers, and the result register. Depends on clook_pkg.
module clook_datapath
	import clook_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int TRACK_BITS  = DEF_TRACK_BITS,
	parameter int TAG_BITS    = DEF_TAG_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_t                  ctl,
	input  logic                  action,
	input  logic [TAG_BITS-1:0]   request_tag,
	input  logic [TRACK_BITS-1:0] request_track,
	input  logic [TRACK_BITS-1:0] head_track,
	output status_t               status,
	output logic [TAG_BITS-1:0]   out_tag,
	output logic [TRACK_BITS-1:0] out_track,
	output logic                  now_empty
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [TAG_BITS-1:0]   tag_q [QUEUE_DEPTH];
	logic [TRACK_BITS-1:0] trk_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]      count_q, wstart_q;
	logic                  wvalid_q;

	logic                   act_s1;
	logic [TAG_BITS-1:0]    tag_s1;
	logic [TRACK_BITS-1:0]  trk_s1;
	logic [QUEUE_DEPTH-1:0] ge_s1;
	logic [CNT_W-1:0]       nws_s1;
	logic                   nwv_s1;

	logic [CNT_W-1:0]       lo, hi, nws;
	logic                   nwv, inner, front_low;
	logic [QUEUE_DEPTH-1:0] ge;

	// Pick the segment that the new entry goes into. Since each segment is
	// sorted, the cells at or after the insert point are exactly those in the
	// segment with a greater track, plus every cell past the segment.
	always_comb begin
		inner     = request_track >= head_track;
		front_low = trk_q[0] < head_track;
		lo        = '0;
		hi        = '0;
		nws       = wstart_q;
		nwv       = wvalid_q;
		if (count_q == '0) begin
			nws = '0;
			nwv = 1'b0;
		end else if (!wvalid_q) begin
			if (inner && front_low) begin
				nws = CNT_W'(1);
				nwv = 1'b1;
			end else if (!inner && !front_low) begin
				// The new entry starts the wrap segment at the tail.
				lo  = count_q;
				hi  = count_q;
				nws = count_q;
				nwv = 1'b1;
			end else begin
				hi = count_q;
			end
		end else if (inner) begin
			hi  = wstart_q;
			nws = wstart_q + CNT_W'(1);
		end else begin
			lo = wstart_q;
			hi = count_q;
		end
	end

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			ge[i] = (CNT_W'(i) >= lo && CNT_W'(i) < hi && trk_q[i] > request_track)
				|| CNT_W'(i) >= hi;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			act_s1 <= action;
			tag_s1 <= request_tag;
			trk_s1 <= request_track;
			ge_s1  <= ge;
			nws_s1 <= nws;
			nwv_s1 <= nwv;
		end
	end

	logic add_ok, take_ok, is_full, is_empty;

	assign is_full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign is_empty = count_q == '0;
	assign add_ok   = act_s1 == ACT_ADD && !is_full;
	assign take_ok  = act_s1 == ACT_TAKE && !is_empty;

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		logic prev_ge;
		logic [TAG_BITS-1:0]   next_tag;
		logic [TRACK_BITS-1:0] next_trk;

		if (g == 0) begin : g_first
			assign prev_ge = 1'b0;
		end else begin : g_rest
			assign prev_ge = ge_s1[g-1];
		end

		// On a take every cell moves one place toward the front.
		if (g == QUEUE_DEPTH - 1) begin : g_last
			assign next_tag = tag_q[g];
			assign next_trk = trk_q[g];
		end else begin : g_mid
			assign next_tag = tag_q[g+1];
			assign next_trk = trk_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (ctl.commit) begin
				if (add_ok) begin
					if (prev_ge) begin
						tag_q[g] <= tag_q[(g == 0) ? 0 : g - 1];
						trk_q[g] <= trk_q[(g == 0) ? 0 : g - 1];
					end else if (ge_s1[g]) begin
						tag_q[g] <= tag_s1;
						trk_q[g] <= trk_s1;
					end
				end else if (take_ok) begin
					tag_q[g] <= next_tag;
					trk_q[g] <= next_trk;
				end
			end
		end
	end

	logic [CNT_W-1:0] count_next, take_ws;
	logic             take_wv;

	always_comb begin
		take_ws = wstart_q;
		take_wv = wvalid_q;
		if (wvalid_q) begin
			if (wstart_q != '0) take_ws = wstart_q - CNT_W'(1);
			if (take_ws == '0) take_wv = 1'b0;
		end
		count_next = count_q;
		if (add_ok) count_next = count_q + CNT_W'(1);
		else if (take_ok) count_next = count_q - CNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wstart_q <= '0;
			wvalid_q <= 1'b0;
		end else if (ctl.commit) begin
			count_q <= count_next;
			if (add_ok) begin
				wstart_q <= nws_s1;
				wvalid_q <= nwv_s1;
			end else if (take_ok) begin
				wstart_q <= take_ws;
				wvalid_q <= take_wv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			out_tag   <= take_ok ? tag_q[0] : '0;
			out_track <= take_ok ? trk_q[0] : '0;
			now_empty <= count_next == '0;
			if (act_s1 == ACT_ADD) status <= is_full ? ST_FULL : ST_OK;
			else status <= is_empty ? ST_EMPTY : ST_OK;
		end
	end

endmodule

// ----- dv/clook_disk_request_queue_tb.sv -----
// Self-checking testbench for clook_disk_request_queue: a directed table, then random add
// and take traffic with stalls on both streams, each result checked against a typed row or a
// scheduler model here. Depends on clook_pkg and clook_disk_request_queue.
module clook_disk_request_queue_tb;
	import clook_pkg::*;

	localparam int QD          = DEF_QUEUE_DEPTH;
	localparam int TRK_W       = DEF_TRACK_BITS;
	localparam int TAG_W       = DEF_TAG_BITS;
	localparam int IN_W        = ((TAG_W + 2 * TRK_W + 7) / 8) * 8;
	localparam int OUT_W       = ((TAG_W + TRK_W + 1 + 7) / 8) * 8;
	localparam int N_RANDOM    = 700;
	localparam int CALM_TAIL   = 100;
	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic             act;
		logic [TAG_W-1:0] tag;
		logic [TRK_W-1:0] trk;
		logic [TRK_W-1:0] head;
	} disk_req_t;

	typedef struct packed {
		status_t          status;
		logic [TAG_W-1:0] tag;
		logic [TRK_W-1:0] trk;
		logic             empty;
	} sched_out_t;

	typedef struct packed {
		disk_req_t  req;
		logic       typed;
		sched_out_t res;
	} dir_row_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata   = '0;
	logic             s_tuser   = 1'b0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0]       m_tuser;

	int         mismatches = 0;
	int         cycles     = 0;
	bit         gaps_on    = 1'b1;
	bit         stalls_on  = 1'b1;
	bit         hold_long  = 1'b0;
	sched_out_t pending_results[$];

	// Scheduler state: slot 0 is the front, the wrap segment starts at wrap_at.
	logic [TAG_W-1:0] slot_tag [QD];
	logic [TRK_W-1:0] slot_trk [QD];
	int               slot_cnt = 0;
	int               wrap_at  = 0;
	bit               wrap_on  = 1'b0;

	// Rows with typed results can be read off directly; the others use the predictor.
	dir_row_t dir_rows [27] = '{
		'{'{ACT_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{ST_EMPTY, 16'h0000, 16'h0000, 1'b1}},
		'{'{ACT_ADD,  16'hFFFF, 16'h0000, 16'h0000}, 1'b1, '{ST_OK,    16'h0000, 16'h0000, 1'b0}},
		'{'{ACT_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{ST_OK,    16'hFFFF, 16'h0000, 1'b1}},
		'{'{ACT_ADD,  16'h0000, 16'hFFFF, 16'hFFFF}, 1'b1, '{ST_OK,    16'h0000, 16'h0000, 1'b0}},
		'{'{ACT_ADD,  16'h0001, 16'h0100, 16'h0200}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_ADD,  16'h0002, 16'h0300, 16'h0200}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_ADD,  16'h0003, 16'h0050, 16'h0200}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_ADD,  16'h0004, 16'h0100, 16'h0200}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_ADD,  16'h0005, 16'h0300, 16'h0000}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_ADD,  16'h0006, 16'h0020, 16'h0080}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{ST_EMPTY, 16'h0000, 16'h0000, 1'b1}},
		'{'{ACT_ADD,  16'h0007, 16'h0010, 16'h0000}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_ADD,  16'h0008, 16'h0500, 16'h0400}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_ADD,  16'h0009, 16'h0005, 16'h0400}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_TAKE, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_ADD,  16'h000A, 16'h0010, 16'h0000}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_ADD,  16'h000B, 16'h0020, 16'h0005}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}},
		'{'{ACT_ADD,  16'h000C, 16'h0008, 16'h0400}, 1'b0, '{ST_OK, 16'h0, 16'h0, 1'b0}}
	};

	clook_disk_request_queue i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	// First slot in [lo, hi) whose track is above trk, so equal tracks stay in arrival order.
	function automatic int first_above(int lo, int hi, logic [TRK_W-1:0] trk);
		for (int i = lo; i < hi; i++)
			if (slot_trk[i] > trk)
				return i;
		return hi;
	endfunction

	function automatic void place(int pos, logic [TAG_W-1:0] tag, logic [TRK_W-1:0] trk);
		for (int i = slot_cnt; i > pos; i--) begin
			slot_tag[i] = slot_tag[i-1];
			slot_trk[i] = slot_trk[i-1];
		end
		slot_tag[pos] = tag;
		slot_trk[pos] = trk;
		slot_cnt++;
	endfunction

	function automatic sched_out_t clook_schedule(disk_req_t r);
		sched_out_t res;
		res = '{ST_OK, '0, '0, 1'b0};
		if (r.act == ACT_ADD) begin
			if (slot_cnt >= QD) begin
				res.status = ST_FULL;
			end else if (slot_cnt == 0) begin
				place(0, r.tag, r.trk);
				wrap_on = 1'b0;
				wrap_at = 0;
			end else if (!wrap_on) begin
				if (r.trk >= r.head && slot_trk[0] < r.head) begin
					// The head has passed everything queued: the new request leads the sweep.
					place(0, r.tag, r.trk);
					wrap_on = 1'b1;
					wrap_at = 1;
				end else if (r.trk < r.head && slot_trk[0] >= r.head) begin
					wrap_at = slot_cnt;
					wrap_on = 1'b1;
					place(slot_cnt, r.tag, r.trk);
				end else begin
					place(first_above(0, slot_cnt, r.trk), r.tag, r.trk);
				end
			end else if (r.trk >= r.head) begin
				place(first_above(0, wrap_at, r.trk), r.tag, r.trk);
				wrap_at++;
			end else begin
				place(first_above(wrap_at, slot_cnt, r.trk), r.tag, r.trk);
			end
		end else if (slot_cnt == 0) begin
			res.status = ST_EMPTY;
		end else begin
			res.tag = slot_tag[0];
			res.trk = slot_trk[0];
			for (int i = 1; i < slot_cnt; i++) begin
				slot_tag[i-1] = slot_tag[i];
				slot_trk[i-1] = slot_trk[i];
			end
			slot_cnt--;
			if (wrap_on) begin
				if (wrap_at > 0)
					wrap_at--;
				if (wrap_at == 0)
					wrap_on = 1'b0;
			end
		end
		res.empty = (slot_cnt == 0);
		return res;
	endfunction

	// Offers one item and books its expected result once it is accepted.
	task automatic send_req(disk_req_t r, logic typed, sched_out_t typed_res);
		sched_out_t pred;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.act;
		s_tdata  <= IN_W'({r.head, r.trk, r.tag});
		do @(posedge clk); while (!s_tready);
		pred = clook_schedule(r);
		pending_results.push_back(typed ? typed_res : pred);
	endtask

	initial begin : source_side
		disk_req_t r;
		int        add_pct;
		bit        narrow;
		add_pct = 50;
		narrow  = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[k])
			send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);

		for (int n = 0; n < N_RANDOM; n++) begin
			// Phases that fill, drain or balance the queue, over a narrow or a full track range.
			if (n % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: add_pct = 25;
					1: add_pct = 50;
					default: add_pct = 80;
				endcase
				narrow = $urandom_range(0, 1);
			end
			if (n == N_RANDOM - CALM_TAIL) begin
				gaps_on   = 1'b0;
				stalls_on = 1'b0;
			end
			if (n == 200) begin
				// The receiver holds off at the start of a burst of adds that fills the queue past full.
				hold_long = 1'b1;
				for (int j = 0; j < 24; j++) begin
					r.act  = ACT_ADD;
					r.tag  = TAG_W'($urandom);
					r.trk  = TRK_W'($urandom_range(0, 63));
					r.head = TRK_W'($urandom_range(0, 63));
					send_req(r, 1'b0, '0);
				end
			end
			if (n == 400) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end
			r.act  = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_TAKE;
			r.tag  = TAG_W'($urandom);
			r.trk  = narrow ? TRK_W'($urandom_range(0, 31)) : TRK_W'($urandom_range(0, 65535));
			r.head = narrow ? TRK_W'($urandom_range(0, 31)) : TRK_W'($urandom_range(0, 65535));
			send_req(r, 1'b0, '0);
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : sink_side
		wait (arst_n === 1'b1);
		forever begin
			if (hold_long) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_long = 1'b0;
			end else if (stalls_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		sched_out_t want;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result item: status %0d, tag %h, track %h",
					m_tuser, m_tdata[TAG_W-1:0], m_tdata[TAG_W +: TRK_W]);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					mismatches++;
				end
				if (m_tdata[TAG_W-1:0] !== want.tag) begin
					$error("out_tag: expected %h, got %h", want.tag, m_tdata[TAG_W-1:0]);
					mismatches++;
				end
				if (m_tdata[TAG_W +: TRK_W] !== want.trk) begin
					$error("out_track: expected %h, got %h", want.trk, m_tdata[TAG_W +: TRK_W]);
					mismatches++;
				end
				if (m_tdata[TAG_W+TRK_W] !== want.empty) begin
					$error("now_empty: expected %0d, got %0d", want.empty, m_tdata[TAG_W+TRK_W]);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
